>>> sv/mff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mff_pkg
// Shared types and constants of the message fragment framer.
// ----------------------------------------------------------------------------
package mff_pkg;

    typedef enum logic [1:0] {
        FLAG_MIDDLE = 2'd0,
        FLAG_FIRST  = 2'd1,
        FLAG_LAST   = 2'd2
    } chunk_flag_t;

    localparam logic [13:0] SEQ_MAX    = 14'd9999;
    localparam logic [15:0] DIGITS_MAX = 16'h9999;
    localparam logic [7:0]  PAD_SINGLE = 8'd35;
    localparam logic [7:0]  PAD_MULTI  = 8'd64;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;

    // control from the framer to the sequence counter
    typedef struct packed {
        logic step;
        logic start;
        logic advance;
        logic clear;
    } seq_ctrl_t;

endpackage
`default_nettype wire

>>> sv/mff_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mff_in_if / mff_out_if
// Valid/ready channels carrying message bytes in and framed bytes out.
// ----------------------------------------------------------------------------
interface mff_in_if #(
    parameter int LENGTH_BITS = 23
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             data_byte;
    logic [LENGTH_BITS-1:0] message_length;

    modport source (output valid, output data_byte, output message_length, input ready);
    modport sink   (input valid, input data_byte, input message_length, output ready);
endinterface

interface mff_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_offset;
    logic        header_valid;
    logic [1:0]  chunk_flag;
    logic [13:0] sequence_number;
    logic [31:0] sequence_text;
    logic [8:0]  pad_count;
    logic [7:0]  pad_character;
    logic        end_of_chunk;
    logic        end_of_message;

    modport source (
        output valid, output payload_byte, output payload_offset, output header_valid,
        output chunk_flag, output sequence_number, output sequence_text,
        output pad_count, output pad_character, output end_of_chunk,
        output end_of_message, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_offset, input header_valid,
        input chunk_flag, input sequence_number, input sequence_text,
        input pad_count, input pad_character, input end_of_chunk,
        input end_of_message, output ready
    );
endinterface
`default_nettype wire

>>> sv/mff_seq_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mff_seq_counter
// Chunk sequence counter, binary and BCD in parallel, saturating at 9999.
// ----------------------------------------------------------------------------
module mff_seq_counter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mff_pkg::seq_ctrl_t ctrl,
    output logic [13:0]            sequence_number,
    output logic [31:0]            sequence_text
);
    import mff_pkg::*;

    logic [13:0] count_reg;
    logic [13:0] count_next;
    logic [15:0] digits_reg;
    logic [15:0] digits_next;
    logic [13:0] count_cur;
    logic [15:0] digits_cur;
    logic [15:0] digits_inc;

    function automatic logic [15:0] bcd_increment(input logic [15:0] d);
        logic [15:0] res;
        logic        carry;
        logic [3:0]  nib;
        res   = '0;
        carry = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            nib = d[4*i +: 4];
            if (carry && nib >= 4'd9)
            begin
                res[4*i +: 4] = 4'd0;
            end
            else
            begin
                res[4*i +: 4] = nib + {3'd0, carry};
                carry = 1'b0;
            end
        end
        return res;
    endfunction

    // a new message starts from chunk zero
    assign count_cur  = ctrl.start ? '0 : count_reg;
    assign digits_cur = ctrl.start ? '0 : digits_reg;
    assign digits_inc = (digits_cur == DIGITS_MAX) ? DIGITS_MAX : bcd_increment(digits_cur);

    assign sequence_number = count_cur;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sequence_text[8*i +: 8] = ASCII_ZERO + {4'd0, digits_cur[4*i +: 4]};
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        digits_next = digits_reg;
        if (ctrl.step)
        begin
            priority if (ctrl.clear)
            begin
                count_next  = '0;
                digits_next = '0;
            end
            else if (ctrl.advance)
            begin
                count_next  = (count_cur < SEQ_MAX) ? count_cur + 14'd1 : SEQ_MAX;
                digits_next = digits_inc;
            end
            else
            begin
                count_next  = count_cur;
                digits_next = digits_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            digits_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            digits_reg <= digits_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SEQ_MAX)
        else $error("sequence count above limit");

    a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (digits_reg == '0))
        else $error("binary and bcd sequence disagree on zero");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && ctrl.clear) |=> (count_reg == '0 && digits_reg == '0))
        else $error("sequence not cleared at end of message");

    a_sat_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == SEQ_MAX) == (digits_reg == DIGITS_MAX))
        else $error("binary and bcd sequence disagree on saturation");

endmodule
`default_nettype wire

>>> sv/message_fragment_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// message_fragment_framer
// Cuts a byte stream into fixed-size payload chunks and tags each byte with
// its offset, chunk header, sequence and end-of-message padding information.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless the output stalls; its framed result
// appears in the output register in the cycle after; the per-byte counter
// update (remaining length, offset and sequence) is combinational, giving one
// transfer per clock. A new byte is taken while the previous result waits,
// as long as that result leaves in the same cycle. The length is sampled
// only on the first byte of a message; a length of zero counts as one.
module message_fragment_framer #(
    parameter int PAYLOAD_BYTES = 494,
    parameter int LENGTH_BITS   = 23
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mff_in_if.sink    message,
    mff_out_if.source fragment
);
    import mff_pkg::*;

    localparam int OW = $clog2(PAYLOAD_BYTES);
    localparam logic [OW-1:0] LAST_OFFSET = OW'(PAYLOAD_BYTES - 1);
    localparam logic [32:0]   CHUNK_LEN   = 33'(PAYLOAD_BYTES);

    logic [LENGTH_BITS-1:0] remaining_reg;
    logic [LENGTH_BITS-1:0] remaining_next;
    logic [OW-1:0]          offset_reg;
    logic [OW-1:0]          offset_next;
    logic                   multi_reg;
    logic                   multi_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   accept;
    logic                   start;
    logic [LENGTH_BITS-1:0] length_eff;
    logic [LENGTH_BITS-1:0] remaining_cur;
    logic [OW-1:0]          offset_cur;
    logic                   multi_cur;
    logic                   header;
    logic                   eom;
    logic                   eoc;
    chunk_flag_t            flag;
    seq_ctrl_t              seq_ctrl;
    logic [13:0]            seq_number;
    logic [31:0]            seq_text;

    logic [7:0]  byte_reg;
    logic [8:0]  offset_out_reg;
    logic        header_reg;
    logic [1:0]  flag_reg;
    logic [13:0] seq_reg;
    logic [31:0] text_reg;
    logic [8:0]  pad_count_reg;
    logic [7:0]  pad_char_reg;
    logic        eoc_reg;
    logic        eom_reg;

    assign message.ready = !out_valid_reg || fragment.ready;
    assign accept        = message.valid && message.ready;

    assign start         = (remaining_reg == '0);
    assign length_eff    = (message.message_length == '0) ? LENGTH_BITS'(1)
                                                          : message.message_length;
    assign remaining_cur = start ? length_eff : remaining_reg;
    assign offset_cur    = start ? '0 : offset_reg;
    assign multi_cur     = start ? ({{(33 - LENGTH_BITS){1'b0}}, length_eff} > CHUNK_LEN)
                                 : multi_reg;

    assign header = (offset_cur == '0);
    assign eom    = (remaining_cur == LENGTH_BITS'(1));
    assign eoc    = eom || (offset_cur == LAST_OFFSET);

    always_comb
    begin
        priority if (!multi_cur)
        begin
            flag = FLAG_LAST;
        end
        else if (seq_number == '0)
        begin
            flag = FLAG_FIRST;
        end
        else if ({{(33 - LENGTH_BITS){1'b0}}, remaining_cur} <= CHUNK_LEN)
        begin
            flag = FLAG_LAST;
        end
        else
        begin
            flag = FLAG_MIDDLE;
        end
    end

    assign seq_ctrl.step    = accept;
    assign seq_ctrl.start   = start;
    assign seq_ctrl.advance = eoc;
    assign seq_ctrl.clear   = eom;

    mff_seq_counter u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (seq_ctrl),
        .sequence_number (seq_number),
        .sequence_text   (seq_text)
    );

    always_comb
    begin
        remaining_next = remaining_reg;
        offset_next    = offset_reg;
        multi_next     = multi_reg;
        if (accept)
        begin
            priority if (eom)
            begin
                remaining_next = '0;
                offset_next    = '0;
                multi_next     = 1'b0;
            end
            else
            begin
                remaining_next = remaining_cur - LENGTH_BITS'(1);
                offset_next    = eoc ? '0 : offset_cur + OW'(1);
                multi_next     = multi_cur;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (fragment.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            offset_reg    <= '0;
            multi_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            offset_reg    <= offset_next;
            multi_reg     <= multi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg       <= message.data_byte;
            offset_out_reg <= 9'(offset_cur);
            header_reg     <= header;
            flag_reg       <= header ? flag : 2'd0;
            seq_reg        <= header ? seq_number : '0;
            text_reg       <= header ? seq_text : '0;
            pad_count_reg  <= eom ? 9'(LAST_OFFSET - offset_cur) : '0;
            pad_char_reg   <= eom ? (multi_cur ? PAD_MULTI : PAD_SINGLE) : '0;
            eoc_reg        <= eoc;
            eom_reg        <= eom;
        end
    end

    assign fragment.valid           = out_valid_reg;
    assign fragment.payload_byte    = byte_reg;
    assign fragment.payload_offset  = offset_out_reg;
    assign fragment.header_valid    = header_reg;
    assign fragment.chunk_flag      = flag_reg;
    assign fragment.sequence_number = seq_reg;
    assign fragment.sequence_text   = text_reg;
    assign fragment.pad_count       = pad_count_reg;
    assign fragment.pad_character   = pad_char_reg;
    assign fragment.end_of_chunk    = eoc_reg;
    assign fragment.end_of_message  = eom_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> message.ready)
        else $error("input stalled with empty output register");

    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        (remaining_reg == '0) |-> (offset_reg == '0 && !multi_reg))
        else $error("stale chunk state between messages");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= LAST_OFFSET)
        else $error("offset beyond chunk size");

    a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eom) |=> (remaining_reg == '0))
        else $error("message state not cleared after last byte");

endmodule
`default_nettype wire
